/* design/tgsw_pkg.sv */
`default_nettype none
package tgsw_pkg;

  localparam int unsigned MaxLevel = 8;
  localparam int unsigned WalkW    = 13;
  localparam int unsigned UvSumW   = 24;
  localparam logic [15:0] UvLo     = 16'd328;
  localparam logic [15:0] UvHi     = 16'd65208;

  localparam logic [2:0] RegLevel  = 3'h0;
  localparam logic [2:0] RegRadius = 3'h4;

  typedef logic signed [4:0] coef_t;
  typedef coef_t vec3_t [3];

  // walk steps per face: down = v2 - v0, left = v1 - v2
  localparam vec3_t DownStep [4] = '{
    '{-5'sd2, 5'sd0, 5'sd2}, '{5'sd2, -5'sd2, 5'sd0},
    '{-5'sd2, 5'sd0, -5'sd2}, '{5'sd2, 5'sd2, 5'sd0}};
  localparam vec3_t LeftStep [4] = '{
    '{5'sd2, -5'sd2, 5'sd0}, '{-5'sd2, 5'sd0, -5'sd2},
    '{5'sd2, 5'sd2, 5'sd0}, '{-5'sd2, 5'sd0, 5'sd2}};
  // twice-u / twice-v weights folded onto the walk axes
  localparam vec3_t UCoef [4] = '{
    '{5'sd2, 5'sd0, 5'sd2}, '{-5'sd2, -5'sd4, 5'sd2},
    '{5'sd6, -5'sd4, -5'sd6}, '{-5'sd6, 5'sd8, -5'sd6}};
  localparam vec3_t VCoef [4] = '{
    '{5'sd0, 5'sd4, 5'sd4}, '{-5'sd8, -5'sd4, 5'sd4},
    '{5'sd0, -5'sd4, -5'sd4}, '{-5'sd8, 5'sd4, -5'sd4}};

  typedef enum logic [2:0] {
    N_IDLE, N_SQ, N_AR, N_AR2, N_SRCH, N_DONE
  } norm_state_e;

  typedef struct packed {
    logic start;
    logic ack;
  } norm_ctl_t;

endpackage
`default_nettype wire

/* design/tetra_geosphere_strip_walker_unit.sv */
`default_nettype none
// From request accept to result valid: 3 square steps, then per axis one a*r multiply,
//   one square and a 16-step restoring search, then one load.
// Requests are not overlapped; the shared multiplier/search unit is the limit, and a
//   stalled output holds the unit (and the input) until the result is taken.
// An advance with no strip running gives no result.
// Reset (rst_ni low, async): no strip running, no result pending, level = 6,
//   sphere_radius = 512 (Q8.8).
module tetra_geosphere_strip_walker_unit (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [2:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic               start_req_i,
  input  wire logic [7:0]         strip_index_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic signed [16:0]      pos_x_o,
  output logic signed [16:0]      pos_y_o,
  output logic signed [16:0]      pos_z_o,
  output logic [15:0]             tex_u_o,
  output logic [15:0]             tex_v_o,
  output logic                    last_o
);
  import tgsw_pkg::*;

  // configuration
  logic [3:0]  level_q;
  logic [15:0] radius_q;
  logic        cfg_we;

  // walk state
  logic signed [WalkW-1:0] wx_q, wy_q, wz_q, wx_d, wy_d, wz_d;
  logic [1:0] face_q, face_d;
  logic [8:0] loop_q, loop_d;
  logic [1:0] phase_q, phase_d;
  logic [7:0] strip_q, strip_d;
  logic       active_q, active_d;

  // request handling
  logic       busy_q;
  logic       accept, emit, is_last;
  logic [1:0] emit_face;
  logic [3:0] lev;
  logic [8:0] n;
  logic [7:0] s_sat;
  logic [8:0] limit;
  logic [15:0] u_val, v_val;
  logic [15:0] u_pend_q, v_pend_q;
  logic        last_pend_q;
  logic        out_valid_q;
  logic        load_out;

  norm_ctl_t   nctl;
  logic        n_done;
  logic signed [16:0] nx, ny, nz;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_comb begin
    unique case (paddr)
      RegLevel:  prdata = {28'd0, level_q};
      RegRadius: prdata = {16'd0, radius_q};
      default:   prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q  <= 4'd6;
      radius_q <= 16'd512;
    end else if (cfg_we) begin
      if (paddr == RegRadius)     radius_q <= pwdata[15:0];
      else if (paddr == RegLevel) level_q  <= pwdata[3:0];
    end
  end

  // level saturates, strips per edge n = 2^level
  assign lev = (level_q > 4'(MaxLevel)) ? 4'(MaxLevel) : level_q;
  assign n   = 9'd1 << lev;
  assign s_sat = ({1'b0, strip_index_i} > n - 9'd1) ? 8'(n - 9'd1) : strip_index_i;

  // pairs allowed on the current face: n-s-1 on even faces, s on odd
  always_comb begin
    if (face_q[0])                          limit = {1'b0, strip_q};
    else if ({1'b0, strip_q} + 9'd1 >= n)   limit = '0;
    else                                    limit = n - {1'b0, strip_q} - 9'd1;
  end

  assign accept = in_valid_i && !in_stall_o;

  // next walk position and which face the emitted vertex belongs to
  always_comb begin
    wx_d = wx_q; wy_d = wy_q; wz_d = wz_q;
    face_d = face_q; loop_d = loop_q; phase_d = phase_q;
    strip_d = strip_q; active_d = active_q;
    emit = 1'b0; is_last = 1'b0; emit_face = face_q;
    if (start_req_i) begin
      strip_d  = s_sat;
      wx_d     = WalkW'($signed({4'd0, n})) - WalkW'($signed({4'd0, s_sat, 1'b0}));
      wy_d     = WalkW'($signed({4'd0, n}));
      wz_d     = -wx_d;
      face_d   = '0;
      loop_d   = '0;
      phase_d  = '0;
      active_d = 1'b1;
      emit     = 1'b1;
      emit_face = '0;
    end else if (active_q) begin
      emit = 1'b1;
      if (phase_q == 2'd0 || phase_q == 2'd2) begin
        // step down
        wx_d = wx_q + WalkW'(DownStep[face_q][0]);
        wy_d = wy_q + WalkW'(DownStep[face_q][1]);
        wz_d = wz_q + WalkW'(DownStep[face_q][2]);
        if (phase_q == 2'd2) loop_d = loop_q + 9'd1;
        phase_d = 2'd1;
      end else begin
        // step left; closing step ends the face
        wx_d = wx_q + WalkW'(LeftStep[face_q][0]);
        wy_d = wy_q + WalkW'(LeftStep[face_q][1]);
        wz_d = wz_q + WalkW'(LeftStep[face_q][2]);
        phase_d = 2'd1;
        if (loop_q < limit) begin
          phase_d = 2'd2;
        end else if (face_q == 2'd3) begin
          active_d = 1'b0;
          is_last  = 1'b1;
        end else begin
          face_d = face_q + 2'd1;
          loop_d = '0;
        end
      end
    end
  end

  // barycentric UV: sum of weights, exact, then shifted to Q0.16 and clamped
  function automatic logic [15:0] uv_value(input logic signed [UvSumW-1:0] sum,
                                           input logic [3:0] lv);
    logic [UvSumW+15:0] v;
    logic [5:0] sh;
    begin
      sh = {2'd0, lv} + 6'd3;
      v  = {sum, 16'd0} >> sh;
      if (sum <= 0)                     uv_value = UvLo;
      else if (v < (UvSumW+16)'(UvLo)) uv_value = UvLo;
      else if (v > (UvSumW+16)'(UvHi)) uv_value = UvHi;
      else                              uv_value = v[15:0];
    end
  endfunction

  always_comb begin
    logic signed [UvSumW-1:0] us, vs;
    us = UvSumW'(wx_d) * UvSumW'(UCoef[emit_face][0])
       + UvSumW'(wy_d) * UvSumW'(UCoef[emit_face][1])
       + UvSumW'(wz_d) * UvSumW'(UCoef[emit_face][2]);
    vs = UvSumW'(wx_d) * UvSumW'(VCoef[emit_face][0])
       + UvSumW'(wy_d) * UvSumW'(VCoef[emit_face][1])
       + UvSumW'(wz_d) * UvSumW'(VCoef[emit_face][2]);
    u_val = uv_value(us, lev);
    v_val = uv_value(vs, lev);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wx_q <= '0; wy_q <= '0; wz_q <= '0;
      face_q <= '0; loop_q <= '0; phase_q <= '0;
      strip_q <= '0; active_q <= 1'b0;
    end else if (accept) begin
      wx_q <= wx_d; wy_q <= wy_d; wz_q <= wz_d;
      face_q <= face_d; loop_q <= loop_d; phase_q <= phase_d;
      strip_q <= strip_d; active_q <= active_d;
    end
  end

  // normalize unit runs while busy; result lands in the output register
  assign nctl.start = accept && emit;
  assign load_out   = n_done && (!out_valid_q || !out_stall_i);
  assign nctl.ack   = load_out;
  assign in_stall_o = busy_q;

  tgsw_norm u_norm (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (nctl),
    .walk_x_i (wx_d),
    .walk_y_i (wy_d),
    .walk_z_i (wz_d),
    .radius_i (radius_q),
    .done_o   (n_done),
    .pos_x_o  (nx),
    .pos_y_o  (ny),
    .pos_z_o  (nz)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (nctl.start)   busy_q <= 1'b1;
      else if (load_out) busy_q <= 1'b0;
      if (load_out)                 out_valid_q <= 1'b1;
      else if (!out_stall_i)        out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (nctl.start) begin
      u_pend_q    <= u_val;
      v_pend_q    <= v_val;
      last_pend_q <= is_last;
    end
    if (load_out) begin
      pos_x_o <= nx;
      pos_y_o <= ny;
      pos_z_o <= nz;
      tex_u_o <= u_pend_q;
      tex_v_o <= v_pend_q;
      last_o  <= last_pend_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
`default_nettype wire

/* design/tgsw_norm.sv */
`default_nettype none
module tgsw_norm (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire tgsw_pkg::norm_ctl_t                ctl_i,
  input  wire logic signed [tgsw_pkg::WalkW-1:0]  walk_x_i,
  input  wire logic signed [tgsw_pkg::WalkW-1:0]  walk_y_i,
  input  wire logic signed [tgsw_pkg::WalkW-1:0]  walk_z_i,
  input  wire logic [15:0]                        radius_i,
  output logic                                    done_o,
  output logic signed [16:0]                      pos_x_o,
  output logic signed [16:0]                      pos_y_o,
  output logic signed [16:0]                      pos_z_o
);
  import tgsw_pkg::*;

  norm_state_e state_q, state_d;
  logic [1:0]  idx_q, idx_d;
  logic [3:0]  bit_q, bit_d;
  logic signed [WalkW-1:0] w_q [3];
  logic [15:0] r_q;
  logic [27:0] s_q, s_d;
  logic [27:0] ar_q, ar_d;
  logic [57:0] rhs_q, rhs_d;
  logic signed [63:0] c2s_q, c2s_d, cs_q, cs_d;
  logic [15:0] mag_q, mag_d;
  logic signed [16:0] res_q [3];
  logic signed [16:0] res_d;
  logic        res_we;

  logic signed [WalkW-1:0] w_sel;
  logic [WalkW-1:0] a_sel;
  logic [27:0] op_a, op_b;
  logic [55:0] prod;
  logic signed [63:0] s_ext, test;
  logic [5:0]  sh1, sh2;

  assign prod = op_a * op_b;
  assign s_ext = $signed({36'd0, s_q});
  assign sh1 = {2'd0, bit_q} + 6'd2;
  assign sh2 = {1'b0, bit_q, 1'b0} + 6'd2;
  assign test = c2s_q + (cs_q <<< sh1) + (s_ext <<< sh2);

  always_comb begin
    case (idx_q)
      2'd0:    w_sel = w_q[0];
      2'd1:    w_sel = w_q[1];
      default: w_sel = w_q[2];
    endcase
    a_sel = w_sel[WalkW-1] ? WalkW'(-w_sel) : WalkW'(w_sel);
  end

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    bit_d   = bit_q;
    s_d     = s_q;
    ar_d    = ar_q;
    rhs_d   = rhs_q;
    c2s_d   = c2s_q;
    cs_d    = cs_q;
    mag_d   = mag_q;
    res_d   = '0;
    res_we  = 1'b0;
    op_a    = 28'(a_sel);
    op_b    = 28'(a_sel);
    done_o  = 1'b0;
    unique case (state_q)
      N_IDLE: begin
        if (ctl_i.start) begin
          state_d = N_SQ;
          idx_d   = 2'd0;
          s_d     = '0;
        end
      end
      N_SQ: begin
        s_d = s_q + prod[27:0];
        if (idx_q == 2'd2) begin
          idx_d   = 2'd0;
          state_d = N_AR;
        end else begin
          idx_d = idx_q + 2'd1;
        end
      end
      N_AR: begin
        op_b    = 28'(r_q);
        ar_d    = prod[27:0];
        state_d = N_AR2;
      end
      N_AR2: begin
        op_a    = ar_q;
        op_b    = ar_q;
        rhs_d   = {prod, 2'b00};
        c2s_d   = s_ext;
        cs_d    = -s_ext;
        mag_d   = '0;
        bit_d   = 4'd15;
        state_d = N_SRCH;
      end
      N_SRCH: begin
        if (test <= $signed({6'd0, rhs_q})) begin
          c2s_d = test;
          cs_d  = cs_q + (s_ext <<< (sh1 - 6'd1));
          mag_d = mag_q | (16'd1 << bit_q);
        end
        bit_d = bit_q - 4'd1;
        if (bit_q == 4'd0) begin
          res_we = 1'b1;
          if (s_q == '0) begin
            res_d = '0;
          end else if (w_sel[WalkW-1]) begin
            res_d = -$signed({1'b0, mag_d});
          end else begin
            res_d = $signed({1'b0, mag_d});
          end
          if (idx_q == 2'd2) begin
            state_d = N_DONE;
          end else begin
            idx_d   = idx_q + 2'd1;
            state_d = N_AR;
          end
        end
      end
      N_DONE: begin
        done_o = 1'b1;
        if (ctl_i.ack) state_d = N_IDLE;
      end
      default: state_d = N_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= N_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    bit_q <= bit_d;
    s_q   <= s_d;
    ar_q  <= ar_d;
    rhs_q <= rhs_d;
    c2s_q <= c2s_d;
    cs_q  <= cs_d;
    mag_q <= mag_d;
    if (state_q == N_IDLE && ctl_i.start) begin
      w_q[0] <= walk_x_i;
      w_q[1] <= walk_y_i;
      w_q[2] <= walk_z_i;
      r_q    <= radius_i;
    end
    if (res_we) begin
      case (idx_q)
        2'd0:    res_q[0] <= res_d;
        2'd1:    res_q[1] <= res_d;
        default: res_q[2] <= res_d;
      endcase
    end
  end

  assign pos_x_o = res_q[0];
  assign pos_y_o = res_q[1];
  assign pos_z_o = res_q[2];

endmodule
`default_nettype wire

/* tb/geosphere_vertex_checker.sv */
`timescale 1ns / 1ps
module geosphere_vertex_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  input  logic               pready,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic               start_req_i,
  input  logic [7:0]         strip_index_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic signed [16:0] pos_x_i,
  input  logic signed [16:0] pos_y_i,
  input  logic signed [16:0] pos_z_i,
  input  logic [15:0]        tex_u_i,
  input  logic [15:0]        tex_v_i,
  input  logic               last_i,
  output int                 pending_o,
  output int                 errors_o
);
  import tgsw_pkg::*;

  typedef struct packed {
    logic signed [16:0] x;
    logic signed [16:0] y;
    logic signed [16:0] z;
    logic [15:0]        u;
    logic [15:0]        v;
    logic               last;
  } vertex_t;

  localparam int TETRA [4][3] = '{'{1, 1, -1}, '{1, -1, 1}, '{-1, 1, 1}, '{-1, -1, -1}};
  // face corners v0, v1, v2, then the opposite corner
  localparam int FACE_VTX [4][4] = '{'{0, 1, 2, 3}, '{2, 3, 1, 0}, '{1, 0, 3, 2},
                                     '{3, 2, 0, 1}};
  localparam int U2 [4][3] = '{'{0, 1, 0}, '{0, 1, 1}, '{1, 2, 1}, '{1, 2, 2}};
  localparam int V2 [4][3] = '{'{0, 0, 2}, '{2, 2, 0}, '{0, 0, 2}, '{2, 2, 0}};

  logic [3:0]  level_q;
  logic [15:0] radius_q;
  int          wx, wy, wz, face_q, pairs_q, phase_q, strip_q;
  bit          active_q;
  vertex_t     vertex_fifo [$];
  int          errors;

  assign pending_o = vertex_fifo.size();
  assign errors_o  = errors;

  function automatic int lev_used();
    return (level_q > MaxLevel) ? MaxLevel : int'(level_q);
  endfunction

  function automatic logic [16:0] scale_axis(int p, longint unsigned s);
    longint unsigned a, rhs, lo, hi, mid, t;
    a   = (p < 0) ? -p : p;
    rhs = 4 * a * a * radius_q * radius_q;
    lo  = 0;
    hi  = 65535;
    if (s == 0) return '0;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      t   = 2 * mid - 1;
      if (t * t * s <= rhs) lo = mid;
      else hi = mid - 1;
    end
    return (p < 0) ? 17'(-lo) : 17'(lo);
  endfunction

  function automatic logic [15:0] uv_clamp(longint sum, int lev);
    longint unsigned v;
    if (sum <= 0) return UvLo;
    v = (longint'(sum) << 16) >> (lev + 3);
    if (v < UvLo) v = UvLo;
    if (v > UvHi) v = UvHi;
    return v[15:0];
  endfunction

  task automatic push_vertex(int f, bit fin);
    vertex_t         e;
    longint unsigned s;
    longint          us, vs, d;
    int              c, m;
    s  = wx * wx + wy * wy + wz * wz;
    us = 0;
    vs = 0;
    m  = FACE_VTX[f][3];
    for (int k = 0; k < 3; k++) begin
      c  = FACE_VTX[f][k];
      d  = wx * (TETRA[c][0] - TETRA[m][0]) + wy * (TETRA[c][1] - TETRA[m][1]) +
           wz * (TETRA[c][2] - TETRA[m][2]);
      us += d * U2[f][k];
      vs += d * V2[f][k];
    end
    e.x    = scale_axis(wx, s);
    e.y    = scale_axis(wy, s);
    e.z    = scale_axis(wz, s);
    e.u    = uv_clamp(us, lev_used());
    e.v    = uv_clamp(vs, lev_used());
    e.last = fin;
    vertex_fifo.insert(vertex_fifo.size(), e);
  endtask

  task automatic walk_edge(int from, int to);
    wx += TETRA[to][0] - TETRA[from][0];
    wy += TETRA[to][1] - TETRA[from][1];
    wz += TETRA[to][2] - TETRA[from][2];
  endtask

  task automatic advance_walk(bit st, int idx);
    int n, f, lim;
    n = 1 << lev_used();
    if (st) begin
      strip_q  = (idx > n - 1) ? n - 1 : idx;
      wx       = n - 2 * strip_q;
      wy       = n;
      wz       = -n + 2 * strip_q;
      face_q   = 0;
      pairs_q  = 0;
      phase_q  = 0;
      active_q = 1;
      push_vertex(0, 0);
    end else if (active_q) begin
      f = face_q;
      if (phase_q != 1) begin
        walk_edge(FACE_VTX[f][0], FACE_VTX[f][2]);
        if (phase_q == 2) pairs_q++;
        phase_q = 1;
        push_vertex(f, 0);
      end else begin
        walk_edge(FACE_VTX[f][2], FACE_VTX[f][1]);
        if (f & 1) lim = strip_q;
        else lim = (strip_q + 1 >= n) ? 0 : n - strip_q - 1;
        if (pairs_q < lim) begin
          phase_q = 2;
          push_vertex(f, 0);
        end else if (f == 3) begin
          active_q = 0;
          push_vertex(f, 1);
        end else begin
          face_q  = f + 1;
          pairs_q = 0;
          push_vertex(f, 0);
        end
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    vertex_t got, want;
    if (!rst_ni) begin
      level_q  = 4'd6;
      radius_q = 16'd512;
      wx = 0; wy = 0; wz = 0;
      face_q = 0; pairs_q = 0; phase_q = 0; strip_q = 0;
      active_q = 0;
      errors   = 0;
      vertex_fifo.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr == RegLevel) level_q = pwdata[3:0];
        else if (paddr == RegRadius) radius_q = pwdata[15:0];
      end
      if (out_valid_i && !out_stall_i) begin
        got = '{pos_x_i, pos_y_i, pos_z_i, tex_u_i, tex_v_i, last_i};
        if (vertex_fifo.size() == 0) begin
          errors++;
          if (errors <= 10) $display("%t: vertex with none expected", $realtime);
        end else begin
          want = vertex_fifo.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= 10)
              $display("%t: vertex mismatch exp x%0d y%0d z%0d u%0d v%0d l%0d",
                $realtime, want.x, want.y, want.z, want.u, want.v, want.last,
                " got x%0d y%0d z%0d u%0d v%0d l%0d",
                got.x, got.y, got.z, got.u, got.v, got.last);
          end
        end
      end
      // request accepted after any output pop this edge, so ordering is kept
      if (in_valid_i && !in_stall_i) advance_walk(start_req_i, strip_index_i);
    end
  end
endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
module testbench;
  import tgsw_pkg::*;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;
  logic               in_valid = 1'b0, start_req = 1'b0;
  logic [7:0]         strip_index = '0;
  logic               in_stall, out_valid;
  logic               out_stall = 1'b0;
  logic signed [16:0] pos_x, pos_y, pos_z;
  logic [15:0]        tex_u, tex_v;
  logic               last;
  int                 pending, errors;

  // sender / receiver pacing controls
  bit                 calm = 1'b0;       // no gaps, no stalls
  bit                 hold_req = 1'b0;   // receiver holds off for a long stretch
  bit                 held_once = 1'b0;
  int                 sent = 0;
  int                 quiet_cycles = 0;

  tetra_geosphere_strip_walker_unit i_dut (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid_i(in_valid), .in_stall_o(in_stall), .start_req_i(start_req),
    .strip_index_i(strip_index), .out_valid_o(out_valid), .out_stall_i(out_stall),
    .pos_x_o(pos_x), .pos_y_o(pos_y), .pos_z_o(pos_z), .tex_u_o(tex_u),
    .tex_v_o(tex_v), .last_o(last)
  );

  geosphere_vertex_checker i_checker (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .in_valid_i(in_valid), .in_stall_i(in_stall), .start_req_i(start_req),
    .strip_index_i(strip_index), .out_valid_i(out_valid), .out_stall_i(out_stall),
    .pos_x_i(pos_x), .pos_y_i(pos_y), .pos_z_i(pos_z), .tex_u_i(tex_u),
    .tex_v_i(tex_v), .last_i(last), .pending_o(pending), .errors_o(errors)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // receiver: random stall runs; one long hold-off on request
  initial begin
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (500) @(posedge clk_i);
        hold_req = 1'b0;
      end else if (calm) begin
        out_stall <= 1'b0;
        @(posedge clk_i);
      end else begin
        out_stall <= ($urandom_range(0, 2) == 0);
        repeat (1 + pick_gap()) @(posedge clk_i);
      end
    end
  end

  // watchdog: cycles with nothing accepted anywhere
  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= 20000) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // one request; returns just after the accepting edge with valid still high
  task automatic send_req(bit st, int idx);
    int g;
    g = pick_gap();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    in_valid    <= 1'b1;
    start_req   <= st;
    strip_index <= idx[7:0];
    forever begin
      @(negedge clk_i);
      if (!in_stall) break;
    end
    @(posedge clk_i);
    sent++;
  endtask

  // drain: all vertices back, then room for a trailing no-result advance
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (70) @(posedge clk_i);
  endtask

  task automatic apb_write(logic [2:0] addr, logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_mode(int lvl, int rad);
    wait_drained();
    apb_write(RegLevel, lvl);
    apb_write(RegRadius, rad);
  endtask

  // start a strip, then advance; the full strip has 4N+2 vertices
  task automatic strip_run(int idx, int adv);
    send_req(1'b1, idx);
    repeat (adv) begin
      if (sent >= 1850) break;
      send_req(1'b0, $urandom_range(0, 255));
    end
  endtask

  initial begin
    int n, kind, budget, lvl, rad;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: smallest sphere, full strip, advance while idle, strip saturation,
    // restart mid strip, oversize level, radius extremes
    set_mode(0, 16'hFFFF);
    strip_run(0, 6);
    strip_run(255, 2);
    strip_run(0, 1);
    set_mode(15, 0);
    strip_run(3, 3);
    set_mode(1, 1);
    send_req(1'b0, 8'hAA);   // continues the running strip under the new level
    strip_run(1, 10);
    send_req(1'b0, 8'h55);

    // random phases; the running strip survives each register change
    while (sent < 1850) begin
      kind = $urandom_range(0, 99);
      lvl  = (kind < 70) ? $urandom_range(0, 3) :
             (kind < 90) ? $urandom_range(4, 6) : $urandom_range(7, 15);
      kind = $urandom_range(0, 3);
      rad  = (kind == 0) ? 0 : (kind == 1) ? 16'hFFFF :
             (kind == 2) ? 512 : $urandom_range(0, 65535);
      set_mode(lvl, rad);
      n      = 1 << ((lvl > MaxLevel) ? MaxLevel : lvl);
      calm   = ($urandom_range(0, 5) == 0);
      if (!held_once && sent > 100) begin
        calm      = 1'b1;
        hold_req  = 1'b1;
        held_once = 1'b1;
      end
      budget = $urandom_range(20, 80);
      while (budget > 0 && sent < 1850) begin
        kind = $urandom_range(0, 9);
        if (kind < 7) begin
          strip_run(($urandom_range(0, 4) == 0) ? $urandom_range(0, 255)
                                                : $urandom_range(0, n - 1),
                    4 * n + 1 + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0));
          budget -= 4 * n + 2;
        end else if (kind == 7) begin
          strip_run($urandom_range(0, 255), $urandom_range(0, 4 * n));
          budget -= 2 * n;
        end else begin
          repeat ($urandom_range(1, 5)) send_req($urandom_range(0, 1), $urandom_range(0, 255));
          budget -= 3;
        end
      end
    end

    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
